FILE: hdl/cwmf_pkg.sv
// Package: shared types and constants of the cross window median filter
`timescale 1ns / 1ps
package cwmf_pkg;
   localparam int MAX_ROWS = 128;
   localparam int MAX_COLS = 128;
   localparam int MAX_RUN = 15;
   localparam int ROW_W = $clog2(MAX_ROWS);
   localparam int COL_W = $clog2(MAX_COLS);
   localparam int ADDR_W = ROW_W + COL_W;
   localparam int NSAMP = 2 * MAX_RUN;
   localparam int CNT_W = $clog2(NSAMP + 1);
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);

   localparam logic [2:0] REG_ROWS = 3'd0;
   localparam logic [2:0] REG_COLS = 3'd1;
   localparam logic [2:0] REG_VLEN = 3'd2;
   localparam logic [2:0] REG_HLEN = 3'd3;
   localparam logic [2:0] REG_RANC = 3'd4;
   localparam logic [2:0] REG_CANC = 3'd5;
   localparam logic [2:0] REG_RPOS = 3'd6;
   localparam logic [2:0] REG_CPOS = 3'd7;

   typedef enum logic {CMD_WRITE = 1'b0, CMD_QUERY = 1'b1} cmd_type;

   typedef struct packed {
      cmd_type         cmd;
      logic [6:0]      row;
      logic [6:0]      col;
      logic [23:0]     pix;
   } item_type;

   typedef struct packed {
      logic [7:0] image_rows;
      logic [7:0] image_cols;
      logic [3:0] vlen;
      logic [3:0] hlen;
      logic [3:0] ranc;
      logic [3:0] canc;
      logic [3:0] rpos;
      logic [3:0] cpos;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_CENTRE, ST_FETCH, ST_DRAIN, ST_SORT, ST_PICK, ST_DONE
   } state_type;

   function automatic logic [9:0] px_sum(input logic [23:0] p);
      px_sum = 10'(p[7:0]) + 10'(p[15:8]) + 10'(p[23:16]);
   endfunction
endpackage

FILE: hdl/cwmf_front.sv
// Front end: accept items and queue them for the back end
`timescale 1ns / 1ps
module cwmf_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  cwmf_pkg::item_type  push_item,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output cwmf_pkg::item_type  head
);
   import cwmf_pkg::*;

   item_type              q_ff [QDEPTH];
   logic [QPTR_W-1:0]     wp_ff, wp_in, rp_ff, rp_in;
   logic [QPTR_W:0]       cnt_ff, cnt_in;

   assign full = cnt_ff == (QPTR_W+1)'(QDEPTH);
   assign empty = cnt_ff == '0;
   assign head = q_ff[rp_ff];

   always_comb begin
      wp_in = push ? wp_ff + 1'b1 : wp_ff;
      rp_in = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= push_item;
      end
   end
endmodule

FILE: hdl/cwmf_back.sv
// Back end: frame memory, cross gather, stable sort and median pick
`timescale 1ns / 1ps
module cwmf_back (
   input  logic                clock,
   input  logic                reset,
   input  cwmf_pkg::cfg_type   cfg,
   input  logic                empty,
   input  cwmf_pkg::item_type  head,
   output logic                pop,
   output logic                idle,
   output logic                rsp_valid,
   output logic [23:0]         rsp_pix
);
   import cwmf_pkg::*;

   logic [23:0]       mem [MAX_ROWS*MAX_COLS];
   logic [23:0]       rd_ff;
   logic [ADDR_W-1:0] raddr;
   logic              rden;

   state_type         st_ff, st_in;
   item_type          it_ff, it_in;
   logic [CNT_W-1:0]  n_ff, n_in;       // total samples
   logic [CNT_W-1:0]  t_ff, t_in;       // issue index
   logic [CNT_W-1:0]  w_ff, w_in;       // write index
   logic              pend_ff, pend_in; // read outstanding
   logic              inside_ff, inside_in;
   logic [23:0]       centre_ff, centre_in;
   logic [23:0]       buf_ff [NSAMP];
   logic [23:0]       buf_in [NSAMP];
   logic [CNT_W-1:0]  pass_ff, pass_in;
   logic              par_ff, par_in;
   logic [23:0]       res_ff, res_in;
   logic              vld_ff, vld_in;

   logic [3:0]        nv, nh;
   logic [7:0]        nr, nc;
   logic signed [9:0] sr, sc;
   logic              in_img;
   logic [3:0]        tt;

   assign nv = (cfg.vlen > 4'(MAX_RUN)) ? 4'(MAX_RUN) : cfg.vlen;
   assign nh = (cfg.hlen > 4'(MAX_RUN)) ? 4'(MAX_RUN) : cfg.hlen;
   assign nr = (cfg.image_rows > 8'(MAX_ROWS)) ? 8'(MAX_ROWS) : cfg.image_rows;
   assign nc = (cfg.image_cols > 8'(MAX_COLS)) ? 8'(MAX_COLS) : cfg.image_cols;

   always_comb begin
      if (t_ff < CNT_W'(nv)) begin
         tt = t_ff[3:0];
         sr = 10'(it_ff.row) - 10'(cfg.ranc) + 10'(tt);
         sc = 10'(it_ff.col) - 10'(cfg.canc) + 10'(cfg.cpos) - 10'sd1;
      end else begin
         tt = 4'(t_ff - CNT_W'(nv));
         sr = 10'(it_ff.row) - 10'(cfg.ranc) + 10'(cfg.rpos) - 10'sd1;
         sc = 10'(it_ff.col) - 10'(cfg.canc) + 10'(tt);
      end
      in_img = (sr >= 0) && (sc >= 0) && (sr < $signed(10'(nr))) && (sc < $signed(10'(nc)));
   end

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: begin
            if (!empty && head.cmd == CMD_QUERY) st_in = ST_CENTRE;
         end
         ST_CENTRE: st_in = (n_ff == '0) ? ST_PICK : ST_FETCH;
         ST_FETCH: begin
            if (t_ff == n_ff - 1'b1) st_in = ST_DRAIN;
         end
         ST_DRAIN: st_in = ST_SORT;
         ST_SORT: begin
            if (pass_ff == n_ff) st_in = ST_PICK;
         end
         ST_PICK: st_in = ST_DONE;
         ST_DONE: st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pop = 1'b0;
      rden = 1'b0;
      raddr = {head.row, head.col};
      it_in = it_ff;
      n_in = n_ff;
      t_in = t_ff;
      w_in = w_ff;
      pend_in = 1'b0;
      inside_in = inside_ff;
      centre_in = centre_ff;
      buf_in = buf_ff;
      pass_in = pass_ff;
      par_in = par_ff;
      res_in = res_ff;
      vld_in = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            if (!empty) begin
               pop = 1'b1;
               it_in = head;
               n_in = CNT_W'(nv) + CNT_W'(nh);
               t_in = '0;
               w_in = '0;
               rden = head.cmd == CMD_QUERY;
            end
         end
         ST_CENTRE: begin
            centre_in = rd_ff;
         end
         ST_FETCH: begin
            raddr = {sr[ROW_W-1:0], sc[COL_W-1:0]};
            rden = in_img;
            pend_in = 1'b1;
            inside_in = in_img;
            t_in = t_ff + 1'b1;
         end
         ST_DRAIN: begin
            pass_in = '0;
            par_in = 1'b0;
         end
         ST_SORT: begin
            // odd-even transposition, one pass per cycle
            for (int i = 0; i < NSAMP - 1; i++) begin
               if ((i[0] == par_ff) && (CNT_W'(i + 1) < n_ff) &&
                   (px_sum(buf_ff[i]) > px_sum(buf_ff[i+1]))) begin
                  buf_in[i] = buf_ff[i+1];
                  buf_in[i+1] = buf_ff[i];
               end
            end
            par_in = ~par_ff;
            pass_in = pass_ff + 1'b1;
         end
         ST_PICK: begin
            res_in = (n_ff == '0) ? centre_ff : buf_ff[n_ff >> 1];
            vld_in = 1'b1;
         end
         default: ;
      endcase
      if (pend_ff) begin
         buf_in[w_ff[$clog2(NSAMP)-1:0]] = inside_ff ? rd_ff : centre_ff;
         w_in = w_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         pend_ff <= 1'b0;
         vld_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         pend_ff <= pend_in;
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      it_ff <= it_in;
      n_ff <= n_in;
      t_ff <= t_in;
      w_ff <= w_in;
      inside_ff <= inside_in;
      centre_ff <= centre_in;
      buf_ff <= buf_in;
      pass_ff <= pass_in;
      par_ff <= par_in;
      res_ff <= res_in;
   end

   always_ff @(posedge clock) begin
      if (st_ff == ST_IDLE && !empty && head.cmd == CMD_WRITE) begin
         mem[{head.row, head.col}] <= head.pix;
      end
      if (rden) begin
         rd_ff <= mem[raddr];
      end
   end

   assign idle = st_ff == ST_IDLE;
   assign rsp_valid = vld_ff;
   assign rsp_pix = res_ff;
endmodule

FILE: hdl/cross_window_color_median_filter_unit.sv
// Top level of the cross window color median filter
`timescale 1ns / 1ps
// Usage: a 128x128 frame of 24-bit pixels is loaded by write items (req_cmd 0)
// and read back filtered by query items (req_cmd 1). An item is taken when
// start is high and busy is low; items enter a four-entry queue, so busy
// rises only when that queue is full.
// A write gives no result. A query reads the centre, then one frame sample
// per cycle over the vlen+hlen cross, sorts the samples with one odd-even
// pass per cycle, and returns the median on rsp_out_ch0..2 with rsp_valid
// high for one cycle. The back end takes the next item only once it is idle.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Registers are written over the csr_ channel whenever csr_valid is high;
// write them only while the block is idle. Reset empties the queue, returns
// the sequencer to idle and restores register defaults; frame contents stay
// undefined until written.
module cross_window_color_median_filter_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_cmd,
   input  logic [6:0]  req_row,
   input  logic [6:0]  req_col,
   input  logic [7:0]  req_ch0,
   input  logic [7:0]  req_ch1,
   input  logic [7:0]  req_ch2,
   output logic        rsp_valid,
   output logic [7:0]  rsp_out_ch0,
   output logic [7:0]  rsp_out_ch1,
   output logic [7:0]  rsp_out_ch2,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_data
);
   import cwmf_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   item_type    push_item, head;
   logic        full, empty, pop, push, idle;
   logic [23:0] pix;

   assign busy = full;
   assign push = start && !busy;
   assign push_item = '{cmd: cmd_type'(req_cmd), row: req_row, col: req_col,
                        pix: {req_ch2, req_ch1, req_ch0}};
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_ROWS: cfg_in.image_rows = csr_data;
            REG_COLS: cfg_in.image_cols = csr_data;
            REG_VLEN: cfg_in.vlen = csr_data[3:0];
            REG_HLEN: cfg_in.hlen = csr_data[3:0];
            REG_RANC: cfg_in.ranc = csr_data[3:0];
            REG_CANC: cfg_in.canc = csr_data[3:0];
            REG_RPOS: cfg_in.rpos = csr_data[3:0];
            REG_CPOS: cfg_in.cpos = csr_data[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{image_rows: 8'd128, image_cols: 8'd128, vlen: 4'd3, hlen: 4'd3,
                     ranc: 4'd1, canc: 4'd1, rpos: 4'd2, cpos: 4'd2};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cwmf_front u_front (
      .clock(clock), .reset(reset), .push(push), .push_item(push_item),
      .full(full), .pop(pop), .empty(empty), .head(head)
   );

   cwmf_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .empty(empty), .head(head),
      .pop(pop), .idle(idle), .rsp_valid(rsp_valid), .rsp_pix(pix)
   );

   assign rsp_out_ch0 = pix[7:0];
   assign rsp_out_ch1 = pix[15:8];
   assign rsp_out_ch2 = pix[23:16];

   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("pop from empty queue");
   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> idle) else $error("pop while back end busy");
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result repeated");
endmodule

FILE: tb/tb.sv
// Testbench for the cross window color median filter: random frame loads and filtered queries
`timescale 1ns / 1ps
module tb;
   import cwmf_pkg::*;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic       req_cmd = 1'b0;
   logic [6:0] req_row = '0;
   logic [6:0] req_col = '0;
   logic [7:0] req_ch0 = '0;
   logic [7:0] req_ch1 = '0;
   logic [7:0] req_ch2 = '0;
   logic       rsp_valid;
   logic [7:0] rsp_out_ch0;
   logic [7:0] rsp_out_ch1;
   logic [7:0] rsp_out_ch2;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [2:0] csr_index = '0;
   logic [7:0] csr_data = '0;

   cross_window_color_median_filter_unit dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   item_type    pending_items[$];
   logic [23:0] median_queue[$];
   logic [23:0] frame_model[MAX_ROWS * MAX_COLS];
   cfg_type     cfg_model;
   int          error_count = 0;
   int          idle_cycles = 0;
   int          burst_left = 0;
   int          gap_left = 0;
   int          accepted_count = 0;
   bit          driver_on = 1'b0;

   function automatic logic [23:0] sample_px(int r, int c, logic [23:0] centre);
      if (r < 0 || c < 0 || r >= int'(cfg_model.image_rows) || r >= MAX_ROWS ||
          c >= int'(cfg_model.image_cols) || c >= MAX_COLS)
         return centre;
      return frame_model[r * MAX_COLS + c];
   endfunction

   function automatic logic [9:0] channel_sum(logic [23:0] p);
      return 10'(p[7:0]) + 10'(p[15:8]) + 10'(p[23:16]);
   endfunction

   function automatic logic [23:0] cross_median(int row, int col);
      logic [23:0] buffer[$];
      logic [23:0] centre;
      logic [23:0] v;
      int          n;
      int          k;
      int          fixed_c;
      int          fixed_r;
      centre = frame_model[row * MAX_COLS + col];
      fixed_c = col - int'(cfg_model.canc) + int'(cfg_model.cpos) - 1;
      fixed_r = row - int'(cfg_model.ranc) + int'(cfg_model.rpos) - 1;
      for (int t = 0; t < int'(cfg_model.vlen); t++)
         buffer.push_back(sample_px(row - int'(cfg_model.ranc) + t, fixed_c, centre));
      for (int t = 0; t < int'(cfg_model.hlen); t++)
         buffer.push_back(sample_px(fixed_r, col - int'(cfg_model.canc) + t, centre));
      n = buffer.size();
      for (int t = 1; t < n; t++) begin
         v = buffer[t];
         k = t;
         while (k > 0 && channel_sum(buffer[k - 1]) > channel_sum(v)) begin
            buffer[k] = buffer[k - 1];
            k--;
         end
         buffer[k] = v;
      end
      return (n == 0) ? centre : buffer[n / 2];
   endfunction

   // driver
   always @(posedge clock) begin
      if (start && !busy) begin
         accepted_count <= accepted_count + 1;
         if (pending_items[0].cmd == CMD_WRITE)
            frame_model[{pending_items[0].row, pending_items[0].col}] = pending_items[0].pix;
         else
            median_queue.push_back(cross_median(pending_items[0].row, pending_items[0].col));
         void'(pending_items.pop_front());
      end
      if (!driver_on || reset || pending_items.size() == 0) begin
         start <= 1'b0;
      end else if (start && busy) begin
         start <= 1'b1;
      end else if (gap_left > 0) begin
         gap_left <= gap_left - 1;
         start <= 1'b0;
      end else begin
         start <= 1'b1;
         req_cmd <= pending_items[0].cmd;
         req_row <= pending_items[0].row;
         req_col <= pending_items[0].col;
         {req_ch2, req_ch1, req_ch0} <= pending_items[0].pix;
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 20);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
         end else begin
            burst_left <= burst_left - 1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (median_queue.size() == 0) begin
            $error("unexpected result %h %h %h", rsp_out_ch0, rsp_out_ch1, rsp_out_ch2);
            error_count++;
         end else begin
            if (rsp_out_ch0 !== median_queue[0][7:0]) begin
               $error("out_ch0 expected %h actual %h", median_queue[0][7:0], rsp_out_ch0);
               error_count++;
            end
            if (rsp_out_ch1 !== median_queue[0][15:8]) begin
               $error("out_ch1 expected %h actual %h", median_queue[0][15:8], rsp_out_ch1);
               error_count++;
            end
            if (rsp_out_ch2 !== median_queue[0][23:16]) begin
               $error("out_ch2 expected %h actual %h", median_queue[0][23:16], rsp_out_ch2);
               error_count++;
            end
            void'(median_queue.pop_front());
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic write_reg(logic [2:0] index, logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         REG_ROWS: cfg_model.image_rows = value;
         REG_COLS: cfg_model.image_cols = value;
         REG_VLEN: cfg_model.vlen = value[3:0];
         REG_HLEN: cfg_model.hlen = value[3:0];
         REG_RANC: cfg_model.ranc = value[3:0];
         REG_CANC: cfg_model.canc = value[3:0];
         REG_RPOS: cfg_model.rpos = value[3:0];
         REG_CPOS: cfg_model.cpos = value[3:0];
         default: ;
      endcase
   endtask

   task automatic set_window(int rows, int cols, int vl, int hl, int ra, int ca,
                             int rp, int cp);
      write_reg(REG_ROWS, 8'(rows));
      write_reg(REG_COLS, 8'(cols));
      write_reg(REG_VLEN, 8'(vl));
      write_reg(REG_HLEN, 8'(hl));
      write_reg(REG_RANC, 8'(ra));
      write_reg(REG_CANC, 8'(ca));
      write_reg(REG_RPOS, 8'(rp));
      write_reg(REG_CPOS, 8'(cp));
      csr_valid <= 1'b0;
   endtask

   task automatic push_item(cmd_type cmd, int row, int col, logic [23:0] pix);
      item_type it;
      it.cmd = cmd;
      it.row = 7'(row);
      it.col = 7'(col);
      it.pix = pix;
      pending_items.push_back(it);
   endtask

   // hold until all items are taken, results drained, and the back end is quiet
   task automatic drain_all();
      driver_on = 1'b1;
      while (pending_items.size() != 0 || median_queue.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      driver_on = 1'b0;
   endtask

   // load a small region fully; queries stay inside it so no unwritten pixel is read
   task automatic load_region(int rows, int cols, bit extremes);
      logic [23:0] p;
      for (int r = 0; r < rows; r++)
         for (int c = 0; c < cols; c++) begin
            case ($urandom_range(0, 5))
               0: p = 24'h000000;
               1: p = 24'hFFFFFF;
               2: p = {3{8'($urandom_range(0, 255))}};
               default: p = 24'($urandom);
            endcase
            if (extremes && r == 0 && c == 0) p = 24'hFFFFFF;
            push_item(CMD_WRITE, r, c, p);
         end
   endtask

   // set the image size to the written region so that every cross sample is written or replaced by the centre
   task automatic random_phase(int queries);
      int rows;
      int cols;
      int vl;
      int hl;
      int ra;
      int ca;
      int rp;
      int cp;
      int qr;
      int qc;
      rows = $urandom_range(1, 12);
      cols = $urandom_range(1, 12);
      vl = $urandom_range(0, 15);
      hl = $urandom_range(0, 15);
      ra = $urandom_range(0, 15);
      ca = $urandom_range(0, 15);
      rp = $urandom_range(0, 15);
      cp = $urandom_range(0, 15);
      set_window(rows, cols, vl, hl, ra, ca, rp, cp);
      load_region(rows, cols, 1'b0);
      for (int i = 0; i < queries; i++) begin
         qr = $urandom_range(0, rows - 1);
         qc = $urandom_range(0, cols - 1);
         if ($urandom_range(0, 7) == 0)
            push_item(CMD_WRITE, qr, qc, 24'($urandom));
         else
            push_item(CMD_QUERY, qr, qc, 24'($urandom));
      end
      drain_all();
   endtask

   initial begin
      cfg_model = '{image_rows: 8'd128, image_cols: 8'd128, vlen: 4'd3, hlen: 4'd3,
                    ranc: 4'd1, canc: 4'd1, rpos: 4'd2, cpos: 4'd2};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: writes at corners of the full store, then queries there with the default window
      push_item(CMD_WRITE, 127, 127, 24'hFFFFFF);
      push_item(CMD_WRITE, 0, 0, 24'h000000);
      push_item(CMD_WRITE, 0, 1, 24'h123456);
      push_item(CMD_WRITE, 1, 0, 24'hFF0000);
      push_item(CMD_WRITE, 1, 1, 24'h00FF00);
      push_item(CMD_WRITE, 127, 126, 24'hAAAAAA);
      push_item(CMD_WRITE, 126, 127, 24'h555555);
      push_item(CMD_WRITE, 126, 126, 24'h0000FF);
      push_item(CMD_QUERY, 0, 0, 24'hFFFFFF);
      push_item(CMD_QUERY, 127, 127, 24'h0);
      drain_all();
      // image zero size: every sample is the centre
      set_window(0, 0, 15, 15, 14, 14, 15, 15);
      push_item(CMD_QUERY, 1, 1, 24'h0);
      push_item(CMD_QUERY, 127, 127, 24'h0);
      drain_all();
      // empty cross, then centre outside image, write outside image
      set_window(1, 1, 0, 0, 0, 0, 1, 1);
      push_item(CMD_QUERY, 0, 1, 24'h0);
      push_item(CMD_WRITE, 127, 127, 24'h7F7F7F);
      push_item(CMD_QUERY, 127, 127, 24'h0);
      drain_all();
      // large image, longest runs, over a fully loaded small corner
      set_window(255, 255, 15, 15, 0, 0, 1, 1);
      load_region(16, 16, 1'b1);
      push_item(CMD_QUERY, 0, 0, 24'h0);
      push_item(CMD_QUERY, 0, 0, 24'h0);
      drain_all();

      while (accepted_count < 400) random_phase($urandom_range(10, 40));

      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
